>>> src/assert_macros.svh
// Assertion macros used by the verification checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous active-low reset disable.
`define DQ_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Condition that must never be seen.
`define DQ_NEVER(lbl, clk, rst_n, cond) \
	`DQ_ASSERT(lbl, clk, rst_n, !(cond))

`endif

>>> src/dq_pkg.sv
// Types and codes for the double-ended queue.
// No dependencies; used by the top level and the checker.
`timescale 1ns / 1ps

package dq_pkg;

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
	localparam logic [2:0] OP_PEEK_BACK  = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] data_in;
	} req_beat_t;

	typedef struct packed {
		logic [31:0] data_out;
		logic [4:0]  count_out;
		logic [1:0]  status;
	} rsp_beat_t;

endpackage

>>> src/dq_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> src/double_ended_queue.sv
// A result passes through the pending stage, then the output register.
// Throughput: one beat per cycle sustained while rsp_stall is low; each read op
// uses the single RAM read port in its accept cycle, and one pending stage plus
// the output register absorb output stall. Reset clears front pointer, count
// and valid flags; RAM contents are left as they are and need no clearing pass.
// Depends on dq_pkg and dq_ram.
`timescale 1ns / 1ps

module double_ended_queue #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  dq_pkg::req_beat_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output dq_pkg::rsp_beat_t rsp
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [IW:0]   DEPTH_W  = (IW + 1)'(DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [IW-1:0] ONE_IDX  = IW'(1);

	function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
		input logic [IW-1:0] off);
		logic [IW:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[IW-1:0];
	endfunction

	logic [IW-1:0] front_q, front_d;
	logic [CW-1:0] count_q, count_d, cnt_m1;
	logic [1:0]    status_d;
	logic          empty, full, accept, s1_move;
	logic          wr_en, rd_en;
	logic [IW-1:0] wr_addr, rd_addr;
	logic [DATA_WIDTH-1:0] wr_data, rd_data;

	logic          valid_s1, read_s1;
	logic [CW-1:0] count_s1;
	logic [1:0]    status_s1;

	logic              rsp_valid_q;
	dq_pkg::rsp_beat_t rsp_q;

	assign empty   = (count_q == '0);
	assign full    = (count_q == FULL_CNT);
	assign cnt_m1  = count_q - CW'(1);
	assign s1_move = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !s1_move;
	assign accept  = req_valid && !req_stall;
	assign wr_data = DATA_WIDTH'(req.data_in);

	always_comb begin
		front_d  = front_q;
		count_d  = count_q;
		status_d = dq_pkg::ST_OK;
		wr_en    = 1'b0;
		wr_addr  = front_q;
		rd_en    = 1'b0;
		rd_addr  = front_q;
		unique case (req.op) inside
			dq_pkg::OP_PUSH_FRONT: begin
				if (full) begin
					status_d = dq_pkg::ST_FULL;
				end else begin
					front_d = (front_q == '0) ? LAST_IDX : front_q - ONE_IDX;
					wr_addr = front_d;
					wr_en   = accept;
					count_d = count_q + CW'(1);
				end
			end
			dq_pkg::OP_PUSH_BACK: begin
				if (full) begin
					status_d = dq_pkg::ST_FULL;
				end else begin
					wr_addr = ring_add(front_q, count_q[IW-1:0]);
					wr_en   = accept;
					count_d = count_q + CW'(1);
				end
			end
			dq_pkg::OP_POP_FRONT, dq_pkg::OP_PEEK_FRONT: begin
				if (empty) begin
					status_d = dq_pkg::ST_EMPTY;
				end else begin
					rd_en   = accept;
					rd_addr = front_q;
					if (req.op == dq_pkg::OP_POP_FRONT) begin
						front_d = ring_add(front_q, ONE_IDX);
						count_d = cnt_m1;
					end
				end
			end
			dq_pkg::OP_POP_BACK, dq_pkg::OP_PEEK_BACK: begin
				if (empty) begin
					status_d = dq_pkg::ST_EMPTY;
				end else begin
					rd_en   = accept;
					rd_addr = ring_add(front_q, cnt_m1[IW-1:0]);
					if (req.op == dq_pkg::OP_POP_BACK) begin
						count_d = cnt_m1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	dq_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				front_q  <= front_d;
				count_q  <= count_d;
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_s1   <= rd_en;
			count_s1  <= count_d;
			status_s1 <= status_d;
		end
		if (s1_move) begin
			rsp_q.data_out  <= read_s1 ? 32'(rd_data) : 32'd0;
			rsp_q.count_out <= 5'(count_s1);
			rsp_q.status    <= status_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> src/dq_checker.sv
// Port-level checks on the result channel of the double-ended queue.
// Depends on dq_pkg and assert_macros.svh; bound to the top level below.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dq_checker #(
	parameter int DEPTH = 16
) (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input dq_pkg::rsp_beat_t rsp
);

	localparam logic [4:0] FULL_CNT = 5'(DEPTH);

	`DQ_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
	`DQ_ASSERT(a_empty_beat, clk, arst_n, rsp_valid && rsp.status == dq_pkg::ST_EMPTY |-> rsp.data_out == 32'd0 && rsp.count_out == 5'd0)
	`DQ_ASSERT(a_full_beat, clk, arst_n, rsp_valid && rsp.status == dq_pkg::ST_FULL |-> rsp.data_out == 32'd0 && rsp.count_out == FULL_CNT)
	`DQ_NEVER(a_bad_status, clk, arst_n, rsp_valid && rsp.status == 2'd3)

endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

>>> dv/double_ended_queue_tb.sv
// Self-checking bench for double_ended_queue: directed table, then biased random ops.
// The ring-store model predicts untyped beats; every beat is checked in order.
// Depends on dq_pkg and the double_ended_queue RTL.
`timescale 1ns / 1ps

module double_ended_queue_tb;

	localparam int unsigned SLOTS = 16;
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;
	localparam int RAND_PER_PHASE = 105;

	typedef struct packed {
		logic [2:0]        op;
		logic [31:0]       data;
		int                reps;
		bit                rand_data;
		bit                typed;
		dq_pkg::rsp_beat_t want;
	} dir_row_t;

	localparam int N_ROWS = 16;
	dir_row_t dir_rows [N_ROWS] = '{
		'{dq_pkg::OP_PEEK_FRONT, 32'h0,        1, 1'b0, 1'b1, '{32'h0, 5'd0, dq_pkg::ST_EMPTY}},
		'{dq_pkg::OP_PEEK_BACK,  32'hffffffff, 1, 1'b0, 1'b1, '{32'h0, 5'd0, dq_pkg::ST_EMPTY}},
		'{dq_pkg::OP_POP_FRONT,  32'hffffffff, 1, 1'b0, 1'b1, '{32'h0, 5'd0, dq_pkg::ST_EMPTY}},
		'{dq_pkg::OP_POP_BACK,   32'h0,        1, 1'b0, 1'b1, '{32'h0, 5'd0, dq_pkg::ST_EMPTY}},
		'{OP_RSVD6,              32'hffffffff, 1, 1'b0, 1'b1, '{32'h0, 5'd0, dq_pkg::ST_OK}},
		'{dq_pkg::OP_PUSH_BACK,  32'hffffffff, 1, 1'b0, 1'b1, '{32'h0, 5'd1, dq_pkg::ST_OK}},
		'{dq_pkg::OP_PUSH_FRONT, 32'h0,        1, 1'b0, 1'b1, '{32'h0, 5'd2, dq_pkg::ST_OK}},
		'{dq_pkg::OP_PEEK_BACK,  32'h0,        1, 1'b0, 1'b1,
			'{32'hffffffff, 5'd2, dq_pkg::ST_OK}},
		'{OP_RSVD7,              32'h12345678, 1, 1'b0, 1'b1, '{32'h0, 5'd2, dq_pkg::ST_OK}},
		'{dq_pkg::OP_POP_BACK,   32'h0,        1, 1'b0, 1'b1,
			'{32'hffffffff, 5'd1, dq_pkg::ST_OK}},
		'{dq_pkg::OP_POP_FRONT,  32'h0,        1, 1'b0, 1'b1, '{32'h0, 5'd0, dq_pkg::ST_OK}},
		// fill from both ends; front pointer wraps below slot zero
		'{dq_pkg::OP_PUSH_FRONT, 32'h0,        8, 1'b1, 1'b0, '0},
		'{dq_pkg::OP_PUSH_BACK,  32'h0,        8, 1'b1, 1'b0, '0},
		'{dq_pkg::OP_PUSH_FRONT, 32'hdeadbeef, 1, 1'b0, 1'b1,
			'{32'h0, 5'd16, dq_pkg::ST_FULL}},
		'{dq_pkg::OP_PUSH_BACK,  32'hffffffff, 1, 1'b0, 1'b1,
			'{32'h0, 5'd16, dq_pkg::ST_FULL}},
		'{dq_pkg::OP_POP_BACK,   32'h0,        1, 1'b0, 1'b0, '0}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	dq_pkg::req_beat_t req = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	dq_pkg::rsp_beat_t rsp;

	logic [31:0] ring [SLOTS];
	logic [3:0]  head = '0;
	logic [4:0]  fill = '0;

	dq_pkg::rsp_beat_t pending_rsp [$];
	int                err_count = 0;
	int                send_idle_pct = 0;
	int                stall_pct = 0;

	double_ended_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #10 clk = ~clk;

	function automatic dq_pkg::rsp_beat_t deque_apply(input dq_pkg::req_beat_t b);
		dq_pkg::rsp_beat_t r;
		logic [3:0]        pos;
		r = '0;
		case (b.op)
			dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
				if (fill == 5'(SLOTS)) begin
					r.status = dq_pkg::ST_FULL;
				end else begin
					if (b.op == dq_pkg::OP_PUSH_FRONT) begin
						head = head - 4'd1;
						ring[head] = b.data_in;
					end else begin
						pos = head + fill[3:0];
						ring[pos] = b.data_in;
					end
					fill = fill + 5'd1;
				end
			end
			dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK, dq_pkg::OP_PEEK_FRONT,
			dq_pkg::OP_PEEK_BACK: begin
				if (fill == 5'd0) begin
					r.status = dq_pkg::ST_EMPTY;
				end else begin
					if (b.op == dq_pkg::OP_POP_FRONT || b.op == dq_pkg::OP_PEEK_FRONT)
						pos = head;
					else
						pos = head + fill[3:0] - 4'd1;
					r.data_out = ring[pos];
					if (b.op == dq_pkg::OP_POP_FRONT) begin
						head = head + 4'd1;
						fill = fill - 5'd1;
					end else if (b.op == dq_pkg::OP_POP_BACK) begin
						fill = fill - 5'd1;
					end
				end
			end
			default: ;
		endcase
		r.count_out = fill;
		return r;
	endfunction

	// Drives one request beat and returns at the edge that accepts it.
	task automatic issue_op(input logic [2:0] op, input logic [31:0] word, input bit typed,
			input dq_pkg::rsp_beat_t typed_rsp);
		dq_pkg::req_beat_t b;
		dq_pkg::rsp_beat_t predicted;
		bit                idled;
		b.op = op;
		b.data_in = word;
		idled = 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			if (!idled)
				req_valid <= 1'b0;
			idled = 1'b1;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= b;
		do
			@(posedge clk);
		while (req_stall);
		predicted = deque_apply(b);
		pending_rsp.push_back(typed ? typed_rsp : predicted);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(7))
			0: return 32'h0;
			1: return 32'hffffffff;
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		dq_pkg::rsp_beat_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					$error("unexpected result beat: data_out %h count_out %0d status %0d",
						rsp.data_out, rsp.count_out, rsp.status);
					err_count++;
				end else begin
					want = pending_rsp.pop_front();
					if (rsp.data_out !== want.data_out) begin
						$error("data_out: expected %h, got %h", want.data_out, rsp.data_out);
						err_count++;
					end
					if (rsp.count_out !== want.count_out) begin
						$error("count_out: expected %0d, got %0d", want.count_out,
							rsp.count_out);
						err_count++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						err_count++;
					end
				end
			end
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		int          phase;
		int          i;
		int          k;
		int          push_bias;
		logic [2:0]  op;
		logic [31:0] word;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_ROWS; i++) begin
			for (k = 0; k < dir_rows[i].reps; k++) begin
				word = dir_rows[i].rand_data ? pick_word() : dir_rows[i].data;
				issue_op(dir_rows[i].op, word, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		push_bias = 50;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 66; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 66; end
				default: begin send_idle_pct = 30; stall_pct = 30; end
			endcase
			for (i = 0; i < RAND_PER_PHASE; i++) begin
				// randomly pick filling or draining runs so full and empty both occur
				if (i % 40 == 0)
					push_bias = $urandom_range(1) ? 78 : 22;
				if ($urandom_range(99) < 3) begin
					op = $urandom_range(1) ? OP_RSVD6 : OP_RSVD7;
				end else if ($urandom_range(99) < push_bias) begin
					op = $urandom_range(1) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK;
				end else begin
					case ($urandom_range(3))
						0: op = dq_pkg::OP_POP_FRONT;
						1: op = dq_pkg::OP_POP_BACK;
						2: op = dq_pkg::OP_PEEK_FRONT;
						default: op = dq_pkg::OP_PEEK_BACK;
					endcase
				end
				issue_op(op, pick_word(), 1'b0, '0);
			end
		end
		req_valid <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		if (err_count == 0)
			$display("double_ended_queue_tb: done, clean");
		else
			$display("double_ended_queue_tb: done, errors");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("double_ended_queue_tb: done, errors");
		$finish;
	end

endmodule

>>> double_ended_queue.f
+incdir+src
src/dq_pkg.sv
src/dq_ram.sv
src/double_ended_queue.sv
src/dq_checker.sv
dv/double_ended_queue_tb.sv
